/* sv/psv_pkg.sv */
// shared types and widths for the per-second vwap block
package psv_pkg;

   // field and accumulator widths
   localparam int TIME_W   = 18;
   localparam int PRICE_W  = 20;
   localparam int SIZE_W   = 24;
   localparam int AVG_W    = 20;
   localparam int SUM_W    = 48;
   localparam int WEIGHT_W = 40;
   localparam int PROD_W   = PRICE_W + SIZE_W;

   // one trade transaction
   typedef struct packed {
      logic [TIME_W-1:0]  time_key;
      logic [PRICE_W-1:0] price_cents;
      logic [SIZE_W-1:0]  trade_size;
      logic               last_item;
   } psv_req_type;

   // one per-second average transaction
   typedef struct packed {
      logic [TIME_W-1:0] bucket_time;
      logic [AVG_W-1:0]  average_price_cents;
      logic              empty_weight;
      logic              last_of_run;
   } psv_rsp_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic done;
      logic empty;
   } psv_div_stat_type;

endpackage

/* sv/psv_div.sv */
// restoring divider, one quotient bit per cycle, with clamp and zero-divisor flag
module psv_div import psv_pkg::*; #(
   parameter int QUOT_WIDTH = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [WEIGHT_W-1:0] divisor,
   output psv_div_stat_type    stat,
   output logic [AVG_W-1:0]    quotient
);

   localparam int DIV_W = WEIGHT_W + QUOT_WIDTH;
   localparam int CNT_W = $clog2(QUOT_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  empty_ff, empty_in;
   logic                  ovf_ff, ovf_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      rem_ff, rem_in;
   logic [DIV_W-1:0]      dvs_ff, dvs_in;
   logic [QUOT_WIDTH-1:0] quo_ff, quo_in;

   logic [DIV_W:0]        trial;
   logic                  fits;

   // shared subtractor: remainder minus shifted divisor
   assign trial = {1'b0, DIV_W'(rem_ff)} - {1'b0, dvs_ff};
   assign fits  = !trial[DIV_W];

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      empty_in = empty_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         empty_in = (divisor == '0);
         ovf_in   = 1'b0;
         cnt_in   = CNT_W'(QUOT_WIDTH);
         rem_in   = dividend;
         dvs_in   = DIV_W'(divisor) << QUOT_WIDTH;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = trial[SUM_W-1:0];
         end
         // first step only tests whether the quotient overflows its width
         if (cnt_ff == CNT_W'(QUOT_WIDTH)) begin
            ovf_in = fits;
         end else begin
            quo_in = {quo_ff[QUOT_WIDTH-2:0], fits};
         end
         dvs_in = dvs_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      empty_ff <= empty_in;
      ovf_ff   <= ovf_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
   end

   // result with clamp and zero-weight override
   always_comb begin
      if (empty_ff) begin
         quotient = '0;
      end else if (ovf_ff) begin
         quotient = AVG_W'({QUOT_WIDTH{1'b1}});
      end else begin
         quotient = AVG_W'(quo_ff);
      end
   end

   assign stat.done  = done_ff;
   assign stat.empty = empty_ff;

endmodule

/* sv/per_second_vwap.sv */
// top level: per-second volume weighted average price over a trade stream
//
//   channel  | direction | handshake             | payload
//   req_     | in        | req_valid / req_ready | psv_req_type (one trade)
//   rsp_     | out       | rsp_valid / rsp_ready | psv_rsp_type (one second)
//
// a trade with no report passes through the idle, multiply, decide and post states; each
// report adds the bit-serial divider (one quotient bit per cycle plus an overflow step),
// the divider's done strobe and the emit state. a trade that closes one second and is also
// last gives two reports. req_ready is high only while idle.
// reset (synchronous) empties the bucket and drops any waiting result.
// a stalled result sits in the output register while the next trade is taken.
module per_second_vwap import psv_pkg::*; #(
   parameter int PRICE_WIDTH = 20,
   parameter int SIZE_WIDTH  = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  psv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output psv_rsp_type rsp_data
);

   localparam int PRICE_USED = (PRICE_WIDTH < PRICE_W) ? PRICE_WIDTH : PRICE_W;
   localparam int SIZE_USED  = (SIZE_WIDTH < SIZE_W) ? SIZE_WIDTH : SIZE_W;
   localparam logic [PRICE_W-1:0] PRICE_MASK = PRICE_W'((64'd1 << PRICE_USED) - 64'd1);
   localparam logic [SIZE_W-1:0]  SIZE_MASK  = SIZE_W'((64'd1 << SIZE_USED) - 64'd1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL    = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_POST   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]          state_ff, state_in;
   psv_req_type         trade_ff, trade_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [TIME_W-1:0]   second_ff, second_in;
   logic                open_ff, open_in;
   logic                phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   psv_rsp_type         rsp_ff, rsp_in;

   logic                div_start;
   psv_div_stat_type    div_stat;
   logic [AVG_W-1:0]    div_avg;

   logic [SUM_W:0]      sum_add;
   logic [SUM_W-1:0]    sum_sat;
   logic [WEIGHT_W:0]   weight_add;
   logic [WEIGHT_W-1:0] weight_sat;

   // saturating accumulation for a trade in the open second
   assign sum_add    = {1'b0, sum_ff} + (SUM_W + 1)'(prod_ff);
   assign sum_sat    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
   assign weight_add = {1'b0, weight_ff} + (WEIGHT_W + 1)'(trade_ff.trade_size);
   assign weight_sat = weight_add[WEIGHT_W] ? '1 : weight_add[WEIGHT_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      trade_in     = trade_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      weight_in    = weight_ff;
      second_in    = second_ff;
      open_in      = open_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               trade_in             = req_data;
               trade_in.price_cents = req_data.price_cents & PRICE_MASK;
               trade_in.trade_size  = req_data.trade_size & SIZE_MASK;
               state_in             = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = trade_ff.price_cents * trade_ff.trade_size;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (open_ff && (trade_ff.time_key != second_ff)) begin
               // close the previous second before opening the new one
               div_start = 1'b1;
               phase_in  = 1'b0;
               state_in  = ST_DIV;
            end else begin
               if (!open_ff) begin
                  sum_in    = SUM_W'(prod_ff);
                  weight_in = WEIGHT_W'(trade_ff.trade_size);
                  second_in = trade_ff.time_key;
                  open_in   = 1'b1;
               end else begin
                  sum_in    = sum_sat;
                  weight_in = weight_sat;
               end
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (trade_ff.last_item) begin
               div_start = 1'b1;
               phase_in  = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_in.bucket_time         = second_ff;
               rsp_in.average_price_cents = div_avg;
               rsp_in.empty_weight        = div_stat.empty;
               rsp_in.last_of_run         = phase_ff || !trade_ff.last_item;
               if (phase_ff) begin
                  // final flush: back to the reset bucket
                  sum_in    = '0;
                  weight_in = '0;
                  second_in = '0;
                  open_in   = 1'b0;
                  state_in  = ST_IDLE;
               end else begin
                  sum_in    = SUM_W'(prod_ff);
                  weight_in = WEIGHT_W'(trade_ff.trade_size);
                  second_in = trade_ff.time_key;
                  open_in   = 1'b1;
                  state_in  = ST_POST;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and bucket state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         weight_ff    <= '0;
         second_ff    <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         weight_ff    <= weight_in;
         second_ff    <= second_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      trade_ff <= trade_in;
      prod_ff  <= prod_in;
      phase_ff <= phase_in;
      rsp_ff   <= rsp_in;
   end

   // shared divider
   psv_div #(
      .QUOT_WIDTH (PRICE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (weight_ff),
      .stat     (div_stat),
      .quotient (div_avg)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/psv_checker.sv */
// port-level checks for the per-second vwap block, bound to the top level
module psv_checker import psv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input psv_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input psv_rsp_type rsp_data
);

   // a stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one trade at a time: busy right after a transaction
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("trade taken while busy");

   // empty second reports a zero average
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_weight |-> rsp_data.average_price_cents == '0)
      else $error("empty second with nonzero average");

   // reset leaves the block idle with no result
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind per_second_vwap psv_checker u_psv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* test/tb_per_second_vwap.sv */
`timescale 1ns / 100ps
// testbench for per_second_vwap: trade stream in, per-second averages checked against a predictor
module tb_per_second_vwap;
   import psv_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 10;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 1550;

   localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
   localparam logic [PRICE_W-1:0]  PRICE_MAX  = '1;
   localparam logic [SIZE_W-1:0]   SIZE_MAX   = '1;
   localparam logic [TIME_W-1:0]   KEY_MAX    = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   psv_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   psv_rsp_type rsp_data;

   // trades waiting to be sent and averages waiting to come back
   psv_req_type trade_queue[$];
   psv_rsp_type average_queue[$];

   // predictor copy of the open bucket
   logic [SUM_W-1:0]    bucket_sum;
   logic [WEIGHT_W-1:0] bucket_weight;
   logic [TIME_W-1:0]   bucket_key;
   logic                bucket_live;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   phase = 0;
   int   fail_count = 0;
   int   quiet_cycles = 0;
   int   hold_count = 0;
   logic hold_done = 1'b0;
   logic req_fire = 1'b0;
   int   clock_second = 0;

   per_second_vwap u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // close the open bucket into one expected average
   function automatic psv_rsp_type close_bucket(logic last_flag);
      psv_rsp_type         r;
      logic [SUM_W-1:0]    quot;
      r.bucket_time = bucket_key;
      r.last_of_run = last_flag;
      if (bucket_weight == '0) begin
         r.average_price_cents = '0;
         r.empty_weight        = 1'b1;
      end else begin
         quot = bucket_sum / {{(SUM_W-WEIGHT_W){1'b0}}, bucket_weight};
         if (quot > {{(SUM_W-PRICE_W){1'b0}}, PRICE_MAX})
            quot = {{(SUM_W-PRICE_W){1'b0}}, PRICE_MAX};
         r.average_price_cents = quot[AVG_W-1:0];
         r.empty_weight        = 1'b0;
      end
      return r;
   endfunction

   // update bucket state for one trade and queue the averages it closes
   function automatic void predict_vwap(psv_req_type t);
      logic [63:0]         product;
      logic [SUM_W-1:0]    product_sat;
      logic [SUM_W:0]      sum_next;
      logic [WEIGHT_W:0]   weight_next;
      product     = {{(64-PRICE_W){1'b0}}, t.price_cents} * {{(64-SIZE_W){1'b0}}, t.trade_size};
      product_sat = (product > {{(64-SUM_W){1'b0}}, SUM_MAX}) ? SUM_MAX : product[SUM_W-1:0];
      if (!bucket_live || t.time_key != bucket_key) begin
         if (bucket_live)
            average_queue.push_back(close_bucket(!t.last_item));
         bucket_key    = t.time_key;
         bucket_sum    = product_sat;
         bucket_weight = {{(WEIGHT_W-SIZE_W){1'b0}}, t.trade_size};
         bucket_live   = 1'b1;
      end else begin
         sum_next      = {1'b0, bucket_sum} + {1'b0, product_sat};
         weight_next   = {1'b0, bucket_weight} + {{(WEIGHT_W-SIZE_W+1){1'b0}}, t.trade_size};
         bucket_sum    = sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
         bucket_weight = weight_next[WEIGHT_W] ? WEIGHT_MAX : weight_next[WEIGHT_W-1:0];
      end
      if (t.last_item) begin
         average_queue.push_back(close_bucket(1'b1));
         bucket_sum    = '0;
         bucket_weight = '0;
         bucket_key    = '0;
         bucket_live   = 1'b0;
      end
   endfunction

   task automatic add_trade(input logic [TIME_W-1:0] key, input logic [PRICE_W-1:0] price,
                            input logic [SIZE_W-1:0] size, input logic last_flag);
      psv_req_type t;
      t.time_key    = key;
      t.price_cents = price;
      t.trade_size  = size;
      t.last_item   = last_flag;
      trade_queue.push_back(t);
   endtask

   // hhmmss key for a running second count
   function automatic logic [TIME_W-1:0] second_key(int s);
      int hh, mm, ss;
      ss = s % 60;
      mm = (s / 60) % 60;
      hh = (s / 3600) % 24;
      return TIME_W'(hh * 10000 + mm * 100 + ss);
   endfunction

   // groups of trades sharing a second, mostly in time order, some odd keys
   task automatic queue_random(int count);
      int                  n, group_len, base_price;
      logic [TIME_W-1:0]   key;
      logic [PRICE_W-1:0]  price;
      logic [SIZE_W-1:0]   size;
      logic                last_flag;
      n = 0;
      while (n < count) begin
         if ($urandom_range(9) == 0) begin
            key = TIME_W'($urandom);
         end else begin
            clock_second = clock_second + (($urandom_range(7) == 0) ? $urandom_range(2, 600) : 1);
            key = second_key(clock_second);
         end
         group_len  = $urandom_range(1, 6);
         base_price = $urandom_range(1000, 500000);
         for (int i = 0; i < group_len && n < count; i++) begin
            case ($urandom_range(9))
               0:       price = PRICE_W'($urandom);
               1:       price = PRICE_MAX;
               default: price = PRICE_W'(base_price + $urandom_range(0, 200) - 100);
            endcase
            case ($urandom_range(19))
               0:       size = '0;
               1, 2:    size = SIZE_W'($urandom);
               3:       size = SIZE_MAX;
               default: size = SIZE_W'($urandom_range(1, 1000));
            endcase
            last_flag = ($urandom_range(39) == 0);
            add_trade(key, price, size, last_flag);
            n++;
         end
      end
   endtask

   task automatic wait_all_done();
      while (trade_queue.size() != 0 || req_valid || average_queue.size() != 0)
         @(posedge clock);
   endtask

   // stimulus and phase control
   initial begin
      bucket_sum    = '0;
      bucket_weight = '0;
      bucket_key    = '0;
      bucket_live   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: first trade, zero size, key change, last with new key, lone last
      send_idle_pct = 18;
      recv_idle_pct = 58;
      add_trade('0, '0, '0, 1'b0);
      add_trade('0, PRICE_MAX, '0, 1'b0);
      add_trade(TIME_W'(1), PRICE_W'(5), SIZE_W'(3), 1'b0);
      add_trade(TIME_W'(1), PRICE_W'(7), SIZE_W'(1), 1'b0);
      add_trade(KEY_MAX, PRICE_W'(100), SIZE_W'(2), 1'b1);
      add_trade(TIME_W'(235959), PRICE_W'(1234), SIZE_W'(10), 1'b1);
      add_trade(TIME_W'(5), PRICE_W'(9), '0, 1'b1);
      // seventeen full-scale trades in one second drive the sum into saturation
      for (int i = 0; i < 17; i++)
         add_trade(TIME_W'(42), PRICE_MAX, SIZE_MAX, (i == 16));
      queue_random(RANDOM_ITEMS / 3);
      wait_all_done();

      // sender pauses here until every average is back
      phase = 1;
      send_idle_pct = 58;
      recv_idle_pct = 18;
      queue_random(RANDOM_ITEMS / 3);
      wait_all_done();

      // no idling; the receiver holds off once to back up the block
      phase = 2;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
      add_trade(second_key(clock_second + 1), PRICE_W'(777), SIZE_W'(5), 1'b1);
      wait_all_done();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // request acceptance seen at the rising edge, used by the driver at the falling edge
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   // trade driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (trade_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= trade_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result ready, with one long hold-off in the last phase
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_count > 0) begin
         rsp_ready  <= 1'b0;
         hold_count <= hold_count - 1;
      end else if (phase == 2 && !hold_done && rsp_valid) begin
         rsp_ready  <= 1'b0;
         hold_count <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: check accepted averages, then predict from accepted trades
   always @(posedge clock) begin
      psv_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (average_queue.size() == 0) begin
               $display("%0t: unexpected average transaction %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = average_queue.pop_front();
               if (rsp_data.bucket_time !== want.bucket_time) begin
                  $display("%0t: bucket_time expected %0d got %0d", $time,
                           want.bucket_time, rsp_data.bucket_time);
                  fail_count++;
               end
               if (rsp_data.average_price_cents !== want.average_price_cents) begin
                  $display("%0t: average_price_cents expected %0d got %0d", $time,
                           want.average_price_cents, rsp_data.average_price_cents);
                  fail_count++;
               end
               if (rsp_data.empty_weight !== want.empty_weight) begin
                  $display("%0t: empty_weight expected %0b got %0b", $time,
                           want.empty_weight, rsp_data.empty_weight);
                  fail_count++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $display("%0t: last_of_run expected %0b got %0b", $time,
                           want.last_of_run, rsp_data.last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            predict_vwap(req_data);
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

/* per_second_vwap.f */
sv/psv_pkg.sv
sv/psv_div.sv
sv/per_second_vwap.sv
sv/psv_checker.sv
test/tb_per_second_vwap.sv
